// File: rtl/core/memory_map_range_carver_defines.svh
// Assertion helpers for the range carver. Clock clk, reset arst_n.
`ifndef MEMORY_MAP_RANGE_CARVER_DEFINES_SVH
`define MEMORY_MAP_RANGE_CARVER_DEFINES_SVH

// Implication checked on every edge outside reset.
`define MMRC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("range carver check failed");

// Condition that must hold on every edge outside reset.
`define MMRC_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("range carver invariant failed");

`endif

// File: rtl/core/mmrc_pkg.sv
`default_nettype none
package mmrc_pkg;
	localparam int FIELD_W       = 48;
	localparam int MAP_DEPTH_DEF = 32;
	localparam int RSV_DEPTH_DEF = 32;
	localparam int ADDR_BITS_DEF = 48;
	localparam int RESULT_CAP    = 32;
	localparam logic [FIELD_W-1:0] NVS_RESET     = 48'h0007_fd67_000;
	localparam logic [FIELD_W-1:0] RECLAIM_RESET = 48'h0007_fd6f_000;

	typedef enum logic [1:0] {
		MODE_CLEAR   = 2'd0,
		MODE_RESERVE = 2'd1,
		MODE_RAM     = 2'd2,
		MODE_EMIT    = 2'd3
	} mode_e;

	typedef enum logic [1:0] {
		ET_MEMORY   = 2'd0,
		ET_RESERVED = 2'd1,
		ET_RECLAIM  = 2'd2,
		ET_NVS      = 2'd3
	} etype_e;

	typedef enum logic [1:0] {
		REG_NVS     = 2'd0,
		REG_RECLAIM = 2'd1
	} reg_e;

	typedef struct packed {
		logic [1:0]         mode;
		logic [FIELD_W-1:0] range_start;
		logic [FIELD_W-1:0] range_end;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] entry_base;
		logic [FIELD_W-1:0] entry_length;
		logic [1:0]         entry_type;
		logic               last_entry;
	} out_item_t;

	// half-open range [lo, hi)
	typedef struct packed {
		logic [FIELD_W-1:0] lo;
		logic [FIELD_W-1:0] hi;
	} range_t;

	// sequencer -> emitter
	typedef struct packed {
		logic       start;
		logic       clr_map;
		logic       push;
		logic       flush;
		range_t     rng;
		logic [1:0] etype;
	} emit_ctl_t;
endpackage
`default_nettype wire

// File: rtl/core/mmrc_ram.sv
`default_nettype none
module mmrc_ram #(
	parameter int W = 96,
	parameter int D = 32
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic                 re,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/mmrc_emit.sv
`default_nettype none
module mmrc_emit
	import mmrc_pkg::*;
#(
	parameter int MAP_DEPTH = MAP_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire emit_ctl_t ctl,
	output logic           hold,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);
	localparam int MUW = $clog2(MAP_DEPTH + 1);
	localparam int CW  = $clog2(RESULT_CAP + 1);

	logic [MUW-1:0] map_used_q;
	logic [CW-1:0]  cnt_q;
	logic           pend_v_q;
	range_t         pend_q;
	logic [1:0]     pend_type_q;
	logic           eligible, need, out_free;

	// one entry held back so the last one can be flagged
	assign eligible = ctl.push && (ctl.rng.lo < ctl.rng.hi)
		&& (map_used_q < MUW'(MAP_DEPTH)) && (cnt_q < CW'(RESULT_CAP));
	assign need     = pend_v_q && (eligible || ctl.flush);
	assign out_free = !out_valid || out_ready;
	assign hold     = need && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_used_q <= '0;
			cnt_q      <= '0;
			pend_v_q   <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (ctl.clr_map) map_used_q <= '0;
			if (ctl.start)   cnt_q      <= '0;
			if (!hold) begin
				if (need) begin
					out_valid <= 1'b1;
				end else if (out_ready) begin
					out_valid <= 1'b0;
				end
				if (eligible) begin
					pend_v_q   <= 1'b1;
					map_used_q <= map_used_q + MUW'(1);
					cnt_q      <= cnt_q + CW'(1);
				end else if (ctl.flush) begin
					pend_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!hold && need) begin
			out_item.entry_base   <= pend_q.lo;
			out_item.entry_length <= pend_q.hi - pend_q.lo;
			out_item.entry_type   <= pend_type_q;
			out_item.last_entry   <= ctl.flush;
		end
		if (!hold && eligible) begin
			pend_q      <= ctl.rng;
			pend_type_q <= ctl.etype;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/memory_map_range_carver.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+----------------------------
// input    | in_valid / in_ready    | in_item  (mode, range)
// output   | out_valid / out_ready  | out_item (one map entry)
// config   | cfg_we                 | cfg_index, cfg_data
//
// One transaction at a time; in_ready is high only while the sequencer idles.
// Clear and reserve complete in the idle state. RAM carving walks the work
// pieces for each stored reserved range, paced by the single-port piece
// memory, then emits them. Reserved emit reads each stored range in turn.
// Async reset clears counters and the sequencer; the range stores are not
// cleared. A stalled output freezes the sequencer only when a further entry
// is ready to leave.
`default_nettype none
`include "memory_map_range_carver_defines.svh"
module memory_map_range_carver
	import mmrc_pkg::*;
#(
	parameter int MAP_DEPTH      = MAP_DEPTH_DEF,
	parameter int RESERVED_DEPTH = RSV_DEPTH_DEF,
	parameter int ADDR_BITS      = ADDR_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire in_item_t     in_item,
	output logic              out_valid,
	input  wire logic         out_ready,
	output out_item_t         out_item,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [FIELD_W-1:0] cfg_data
);
	localparam int MI   = $clog2(MAP_DEPTH);
	localparam int RI   = $clog2(RESERVED_DEPTH);
	localparam int NW   = $clog2(MAP_DEPTH + 1);
	localparam int UW   = $clog2(RESERVED_DEPTH + 1);
	localparam int IW   = (NW > UW) ? NW : UW;
	localparam int KEEP = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
	localparam logic [FIELD_W-1:0] AMASK = {FIELD_W{1'b1}} >> (FIELD_W - KEEP);
	localparam int RW   = 2 * FIELD_W;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_R_RD  = 11'b000_0000_0010,
		S_P_RD  = 11'b000_0000_0100,
		S_P_EV  = 11'b000_0000_1000,
		S_P_MV  = 11'b000_0001_0000,
		S_P_SP  = 11'b000_0010_0000,
		S_E_RD  = 11'b000_0100_0000,
		S_E_CHK = 11'b000_1000_0000,
		S_M_RD  = 11'b001_0000_0000,
		S_M_CHK = 11'b010_0000_0000,
		S_FIN   = 11'b100_0000_0000
	} state_e;

	state_e st_q, st_d;
	logic [IW-1:0] i_q, i_d;
	logic [NW-1:0] n_q, n_d, nm1;
	logic [UW-1:0] r_q, r_d, used_q, used_d;
	logic [FIELD_W-1:0] nvs_q, reclaim_q, s_in, e_in;

	logic          pm_we, pm_re, rm_we, rm_re;
	logic [MI-1:0] pm_wa, pm_ra;
	logic [RI-1:0] rm_wa, rm_ra;
	range_t        pm_wd, rm_wd, pc, rv;
	logic [RW-1:0] pm_rdata, rm_rdata;
	emit_ctl_t     ctl;
	logic          hold;

	assign s_in = in_item.range_start & AMASK;
	assign e_in = in_item.range_end & AMASK;
	assign pc   = range_t'(pm_rdata);   // current work piece
	assign rv   = range_t'(rm_rdata);   // current reserved range
	assign nm1  = n_q - NW'(1);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nvs_q     <= NVS_RESET;
			reclaim_q <= RECLAIM_RESET;
		end else if (cfg_we) begin
			priority case (cfg_index)
				REG_NVS:     nvs_q     <= cfg_data;
				REG_RECLAIM: reclaim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mmrc_ram #(.W(RW), .D(MAP_DEPTH)) u_piece_ram (
		.clk(clk), .we(pm_we), .waddr(pm_wa), .wdata(pm_wd),
		.re(pm_re), .raddr(pm_ra), .rdata(pm_rdata)
	);

	mmrc_ram #(.W(RW), .D(RESERVED_DEPTH)) u_rsv_ram (
		.clk(clk), .we(rm_we), .waddr(rm_wa), .wdata(rm_wd),
		.re(rm_re), .raddr(rm_ra), .rdata(rm_rdata)
	);

	mmrc_emit #(.MAP_DEPTH(MAP_DEPTH)) u_emit (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .hold(hold),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	// Sequencer. Each state does at most one piece memory access, so a
	// write and a read of the same entry never meet in one cycle; the read
	// word stays put in the RAM's output register until the next read.
	always_comb begin
		st_d = st_q; i_d = i_q; n_d = n_q; r_d = r_q; used_d = used_q;
		pm_we = 1'b0; pm_wa = '0; pm_wd = '0; pm_re = 1'b0; pm_ra = '0;
		rm_we = 1'b0; rm_wa = '0; rm_wd = '0; rm_re = 1'b0; rm_ra = '0;
		ctl = '0;
		in_ready = (st_q == S_IDLE);
		unique case (st_q)
			S_IDLE: if (in_valid) begin
				unique case (in_item.mode)
					MODE_CLEAR: begin
						used_d      = '0;
						ctl.clr_map = 1'b1;
					end
					MODE_RESERVE: if (s_in < e_in && used_q < UW'(RESERVED_DEPTH)) begin
						rm_we  = 1'b1;
						rm_wa  = used_q[RI-1:0];
						rm_wd  = '{lo: s_in, hi: e_in};
						used_d = used_q + UW'(1);
					end
					MODE_RAM: begin
						pm_we     = 1'b1;
						pm_wa     = '0;
						pm_wd     = '{lo: s_in, hi: e_in};
						n_d       = NW'(1);
						r_d       = '0;
						i_d       = '0;
						ctl.start = 1'b1;
						st_d      = (used_q == '0) ? S_E_RD : S_R_RD;
					end
					MODE_EMIT: begin
						i_d       = '0;
						ctl.start = 1'b1;
						st_d      = S_M_RD;
					end
					default: ;
				endcase
			end
			S_R_RD: begin
				rm_re = 1'b1;
				rm_ra = r_q[RI-1:0];
				i_d   = '0;
				st_d  = S_P_RD;
			end
			S_P_RD: begin
				if (i_q < IW'(n_q)) begin
					pm_re = 1'b1;
					pm_ra = i_q[MI-1:0];
					st_d  = S_P_EV;
				end else begin
					r_d = r_q + UW'(1);
					i_d = '0;
					st_d = (r_q + UW'(1) < used_q) ? S_R_RD : S_E_RD;
				end
			end
			S_P_EV: begin
				if (rv.hi <= pc.lo || rv.lo >= pc.hi) begin
					i_d  = i_q + IW'(1);
					st_d = S_P_RD;
				end else if (rv.lo <= pc.lo && rv.hi >= pc.hi) begin
					// covered: last piece moves into this slot and is re-examined
					n_d = nm1;
					if (IW'(nm1) == i_q) begin
						st_d = S_P_RD;
					end else begin
						pm_re = 1'b1;
						pm_ra = nm1[MI-1:0];
						st_d  = S_P_MV;
					end
				end else if (rv.lo <= pc.lo) begin
					pm_we = 1'b1;
					pm_wa = i_q[MI-1:0];
					pm_wd = '{lo: rv.hi, hi: pc.hi};
					i_d   = i_q + IW'(1);
					st_d  = S_P_RD;
				end else if (rv.hi >= pc.hi) begin
					pm_we = 1'b1;
					pm_wa = i_q[MI-1:0];
					pm_wd = '{lo: pc.lo, hi: rv.lo};
					i_d   = i_q + IW'(1);
					st_d  = S_P_RD;
				end else begin
					// inner hit: upper half appended if there is room
					if (n_q < NW'(MAP_DEPTH)) begin
						pm_we = 1'b1;
						pm_wa = n_q[MI-1:0];
						pm_wd = '{lo: rv.hi, hi: pc.hi};
						n_d   = n_q + NW'(1);
					end
					st_d = S_P_SP;
				end
			end
			S_P_MV: begin
				pm_we = 1'b1;
				pm_wa = i_q[MI-1:0];
				pm_wd = pc;
				st_d  = S_P_EV;
			end
			S_P_SP: begin
				pm_we = 1'b1;
				pm_wa = i_q[MI-1:0];
				pm_wd = '{lo: pc.lo, hi: rv.lo};
				i_d   = i_q + IW'(1);
				st_d  = S_P_RD;
			end
			S_E_RD: begin
				if (i_q < IW'(n_q)) begin
					pm_re = 1'b1;
					pm_ra = i_q[MI-1:0];
					st_d  = S_E_CHK;
				end else begin
					st_d = S_FIN;
				end
			end
			S_E_CHK: begin
				ctl.push  = 1'b1;
				ctl.rng   = pc;
				ctl.etype = ET_MEMORY;
				if (!hold) begin
					i_d  = i_q + IW'(1);
					st_d = S_E_RD;
				end
			end
			S_M_RD: begin
				if (i_q < IW'(used_q)) begin
					rm_re = 1'b1;
					rm_ra = i_q[RI-1:0];
					st_d  = S_M_CHK;
				end else begin
					st_d = S_FIN;
				end
			end
			S_M_CHK: begin
				ctl.push = 1'b1;
				ctl.rng  = rv;
				priority if (rv.lo == nvs_q)     ctl.etype = ET_NVS;
				else if     (rv.lo == reclaim_q) ctl.etype = ET_RECLAIM;
				else                             ctl.etype = ET_RESERVED;
				if (!hold) begin
					i_d  = i_q + IW'(1);
					st_d = S_M_RD;
				end
			end
			S_FIN: begin
				ctl.flush = 1'b1;
				if (!hold) st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			i_q    <= '0;
			n_q    <= '0;
			r_q    <= '0;
			used_q <= '0;
		end else begin
			st_q   <= st_d;
			i_q    <= i_d;
			n_q    <= n_d;
			r_q    <= r_d;
			used_q <= used_d;
		end
	end

	// work list and reserved store never overrun their memories
	`MMRC_ASSERT_ALWAYS(a_pieces_bound, n_q <= NW'(MAP_DEPTH) && used_q <= UW'(RESERVED_DEPTH))
	// carve cursor never passes the live piece count
	`MMRC_ASSERT_IMP(a_cursor_bound, st_q == S_P_RD || st_q == S_P_EV, i_q <= IW'(n_q))
	// the sequencer only stalls on a blocked output register
	`MMRC_ASSERT_IMP(a_hold_cause, hold, out_valid && !out_ready)
endmodule
`default_nettype wire

// File: verif/testbench.sv
`default_nettype none
module testbench;
	import mmrc_pkg::*;

	// run budget: watchdog limit and post-queue drain wait
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 4000;
	localparam int N_RANDOM = 177;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [FIELD_W-1:0] cfg_data = '0;

	memory_map_range_carver i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow of the block's state
	logic [FIELD_W-1:0] nvs_q, reclaim_q;
	logic [FIELD_W-1:0] rsv_lo [RSV_DEPTH_DEF];
	logic [FIELD_W-1:0] rsv_hi [RSV_DEPTH_DEF];
	int rsv_count, map_count;
	out_item_t entry_queue[$];
	int failures = 0;
	int cycles = 0;
	bit hold_off = 1'b0;

	// append one entry unless empty, map full or per-transaction cap hit
	function automatic void push_entry(input logic [FIELD_W-1:0] lo, input logic [FIELD_W-1:0] hi,
			input logic [1:0] et, inout int n);
		out_item_t o;
		if (lo >= hi || map_count >= MAP_DEPTH_DEF || n >= RESULT_CAP) return;
		o.entry_base = lo;
		o.entry_length = hi - lo;
		o.entry_type = et;
		o.last_entry = 1'b0;
		entry_queue.push_back(o);
		map_count++;
		n++;
	endfunction

	// works out the entries one accepted transaction produces
	function automatic void predict_map(input in_item_t it);
		logic [FIELD_W-1:0] plo [MAP_DEPTH_DEF];
		logic [FIELD_W-1:0] phi [MAP_DEPTH_DEF];
		logic [FIELD_W-1:0] s, e, rs, re;
		int n, i, nout;
		logic [1:0] et;
		nout = 0;
		case (mode_e'(it.mode))
			MODE_CLEAR: begin
				rsv_count = 0;
				map_count = 0;
			end
			MODE_RESERVE: begin
				if (it.range_start < it.range_end && rsv_count < RSV_DEPTH_DEF) begin
					rsv_lo[rsv_count] = it.range_start;
					rsv_hi[rsv_count] = it.range_end;
					rsv_count++;
				end
			end
			MODE_RAM: begin
				for (i = 0; i < MAP_DEPTH_DEF; i++) begin
					plo[i] = '0;
					phi[i] = '0;
				end
				plo[0] = it.range_start;
				phi[0] = it.range_end;
				n = 1;
				for (int r = 0; r < rsv_count; r++) begin
					rs = rsv_lo[r];
					re = rsv_hi[r];
					i = 0;
					while (i < n) begin
						s = plo[i];
						e = phi[i];
						if (re <= s || rs >= e) begin
							i++;
						end else if (rs <= s && re >= e) begin
							// covered: last piece moves into the hole
							plo[i] = plo[n-1];
							phi[i] = phi[n-1];
							n--;
						end else if (rs <= s) begin
							plo[i] = re;
							i++;
						end else if (re >= e) begin
							phi[i] = rs;
							i++;
						end else begin
							// inner hole: upper half appended while room remains
							if (n < MAP_DEPTH_DEF) begin
								plo[n] = re;
								phi[n] = e;
								n++;
							end
							phi[i] = rs;
							i++;
						end
					end
				end
				for (i = n; i < MAP_DEPTH_DEF; i++) begin
					plo[i] = '0;
					phi[i] = '0;
				end
				for (i = 0; i < MAP_DEPTH_DEF; i++)
					push_entry(plo[i], phi[i], ET_MEMORY, nout);
			end
			default: begin
				for (i = 0; i < rsv_count; i++) begin
					// NVS wins when both registers match
					if (rsv_lo[i] == nvs_q) et = ET_NVS;
					else if (rsv_lo[i] == reclaim_q) et = ET_RECLAIM;
					else et = ET_RESERVED;
					push_entry(rsv_lo[i], rsv_hi[i], et, nout);
				end
			end
		endcase
		if (nout > 0) entry_queue[$].last_entry = 1'b1;
	endfunction

	// directed table; exp_n >= 0 means the count of entries is known by eye
	typedef struct {
		in_item_t it;
		int exp_n;
	} row_t;
	localparam logic [FIELD_W-1:0] TOP = {FIELD_W{1'b1}};
	row_t dir_rows[] = '{
		'{'{MODE_EMIT, '0, '0}, 0},                  // nothing stored after reset
		'{'{MODE_RAM, '0, TOP}, 1},                   // whole space, nothing carved
		'{'{MODE_RAM, 48'h100, 48'h100}, 0},          // empty RAM range
		'{'{MODE_RESERVE, 48'h500, 48'h400}, 0},      // inverted: ignored
		'{'{MODE_RESERVE, 48'h1000, 48'h2000}, 0},
		'{'{MODE_RESERVE, NVS_RESET, NVS_RESET + 48'h8000}, 0},
		'{'{MODE_RESERVE, RECLAIM_RESET, RECLAIM_RESET + 48'h1000}, 0},
		'{'{MODE_RAM, 48'h0, 48'h3000}, -1},          // split
		'{'{MODE_RAM, 48'h1000, 48'h2000}, 0},        // fully covered
		'{'{MODE_RAM, 48'h800, 48'h1800}, -1},        // trim top
		'{'{MODE_RAM, 48'h1800, 48'h2800}, -1},       // trim bottom
		'{'{MODE_EMIT, '0, '0}, -1},
		'{'{MODE_CLEAR, TOP, TOP}, 0},
		'{'{MODE_RESERVE, TOP - 1, TOP}, 0},
		'{'{MODE_RESERVE, '0, 48'h1}, 0},
		'{'{MODE_EMIT, TOP, '0}, 2},
		'{'{MODE_RAM, '0, TOP}, -1},
		'{'{MODE_CLEAR, '0, '0}, 0}
	};

	// valid stays up after acceptance; the caller drops it or sends the next one
	task automatic send_item(input in_item_t it);
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		predict_map(it);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (entry_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_e idx, input logic [FIELD_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_NVS) nvs_q = val;
		else reclaim_q = val;
		@(posedge clk);
	endtask

	// address drawn near a small pool of hot values so ranges overlap
	function automatic logic [FIELD_W-1:0] rand_addr();
		case ($urandom_range(0, 9))
			0: return FIELD_W'({$urandom, $urandom});
			1: return TOP - $urandom_range(0, 3);
			2: return nvs_q;
			3: return reclaim_q;
			default: return 48'h1000 * $urandom_range(0, 16);
		endcase
	endfunction

	function automatic in_item_t rand_item(input logic [1:0] m);
		in_item_t it;
		logic [FIELD_W-1:0] a, b;
		a = rand_addr();
		b = rand_addr();
		it.mode = m;
		// mostly well-formed ranges; occasionally inverted ones
		if ($urandom_range(0, 7) != 0 && a > b) begin
			it.range_start = b;
			it.range_end = a;
		end else begin
			it.range_start = a;
			it.range_end = b;
		end
		return it;
	endfunction

	task automatic random_phase(input int count);
		int k, gap;
		logic [1:0] m;
		k = 0;
		while (k < count) begin
			// burst, then a gap
			for (int b = $urandom_range(1, 8); b > 0 && k < count; b--) begin
				case ($urandom_range(0, 19))
					0: m = MODE_CLEAR;
					1, 2, 3, 4, 5, 6, 7, 8: m = MODE_RESERVE;
					9, 10, 11, 12, 13, 14, 15: m = MODE_RAM;
					default: m = MODE_EMIT;
				endcase
				send_item(rand_item(m));
				k++;
			end
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// receiver: own stall pattern, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_off) out_ready <= 1'b0;
		else if (cycles % 64 < 20) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 3) != 0);
	end

	// checker: compare each accepted entry with the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (entry_queue.size() == 0) begin
				$error("unexpected entry base=%h", out_item.entry_base);
				failures++;
			end else begin
				want = entry_queue.pop_front();
				if (out_item.entry_base !== want.entry_base) begin
					$error("entry_base: expected %h, got %h", want.entry_base, out_item.entry_base);
					failures++;
				end
				if (out_item.entry_length !== want.entry_length) begin
					$error("entry_length: expected %h, got %h",
						want.entry_length, out_item.entry_length);
					failures++;
				end
				if (out_item.entry_type !== want.entry_type) begin
					$error("entry_type: expected %0d, got %0d", want.entry_type, out_item.entry_type);
					failures++;
				end
				if (out_item.last_entry !== want.last_entry) begin
					$error("last_entry: expected %0d, got %0d", want.last_entry, out_item.last_entry);
					failures++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int before_n;
		nvs_q = NVS_RESET;
		reclaim_q = RECLAIM_RESET;
		rsv_count = 0;
		map_count = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows; eye-readable counts checked on top of the predictor
		foreach (dir_rows[r]) begin
			before_n = entry_queue.size();
			send_item(dir_rows[r].it);
			if (dir_rows[r].exp_n >= 0 && entry_queue.size() - before_n != dir_rows[r].exp_n) begin
				$error("row %0d entry count: expected %0d, got %0d", r, dir_rows[r].exp_n,
					entry_queue.size() - before_n);
				failures++;
			end
			wait_idle();
		end

		// fill the reserved store past capacity, then hold the receiver off
		for (int k = 0; k < 34; k++)
			send_item('{MODE_RESERVE, 48'h2000 * k + 48'h800, 48'h2000 * k + 48'h1000});
		hold_off = 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				send_item('{MODE_EMIT, '0, '0});
				send_item('{MODE_CLEAR, '0, '0});
				send_item('{MODE_RAM, '0, 48'h40000});
			end
		join
		wait_idle();

		// several register settings, extremes included
		write_reg(REG_NVS, '0);
		write_reg(REG_RECLAIM, TOP);
		random_phase(N_RANDOM / 3);
		wait_idle();
		write_reg(REG_NVS, 48'h1000);
		write_reg(REG_RECLAIM, 48'h1000);
		random_phase(N_RANDOM / 3);
		wait_idle();
		write_reg(REG_NVS, TOP);
		write_reg(REG_RECLAIM, FIELD_W'({$urandom, $urandom}));
		random_phase(N_RANDOM / 3);
		wait_idle();

		if (failures == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire

// File: memory_map_range_carver.f
+incdir+rtl/core
rtl/core/mmrc_pkg.sv
rtl/core/mmrc_ram.sv
rtl/core/mmrc_emit.sv
rtl/core/memory_map_range_carver.sv
verif/testbench.sv
